// ----- hdl/lpr_pkg.sv -----
// Shared types, result codes and prefix helpers for the longest-prefix route lookup.
package lpr_pkg;

	// Item operation codes.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_ROUTE = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_STORED      = 3'd0;
	localparam logic [2:0] ST_FORWARDED   = 3'd1;
	localparam logic [2:0] ST_DROPPED_TTL = 3'd2;
	localparam logic [2:0] ST_NO_ROUTE    = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

	// Longest legal prefix length.
	localparam logic [5:0] MAX_LEN = 6'd32;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// One stored route.
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [2:0]  iface;
		logic        has_gw;
		logic [31:0] gw;
	} entry_t;

	// Verdict of the shared compare unit on one entry.
	typedef struct packed {
		logic same;
		logic hit;
		logic longer;
	} cmp_res_t;

	// Clamp a prefix length to 32.
	function automatic logic [5:0] clamp_len(input logic [5:0] len);
		clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
	endfunction

	// Network mask with the given number of leading ones.
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		prefix_mask = ~(32'hFFFF_FFFF >> clamp_len(len));
	endfunction

endpackage

// ----- hdl/ipv4_longest_prefix_router.sv -----
// Top level of the IPv4 longest-prefix route table and lookup engine.
//
// Usage: present a word on the input ports with start high; it is taken at a
// rising edge where start is high and busy is low. op selects between adding
// a route and routing one datagram header. Busy stays high while the word is
// worked on, and no new word is taken meanwhile.
// Each word gives exactly one result word, shown for one cycle with done high.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// The table memory is read through its single read port, one stored route per
// cycle, and every entry goes through one shared compare unit. A header with a
// TTL of 0 or 1, or any word on an empty table, skips the scan and goes
// straight to the finish state. The next word can be accepted in the cycle the
// result is shown.
// Routes fill the table from slot 0 upward and are never removed, so a fill
// count stands for the valid bits. Reset empties the table at once; there is
// no clearing pass.
module ipv4_longest_prefix_router #(
	parameter int MAX_ROUTES     = 64,
	parameter int NUM_INTERFACES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] route_net,
	input  logic [5:0]  route_len,
	input  logic        has_next_hop,
	input  logic [31:0] next_hop_addr,
	input  logic [2:0]  route_interface,
	input  logic [31:0] dst_addr,
	input  logic [7:0]  ttl_in,
	output logic        done,
	output logic [2:0]  status,
	output logic [2:0]  out_interface,
	output logic [31:0] deliver_addr,
	output logic [7:0]  ttl_out
);
	import lpr_pkg::*;

	localparam int ADDR_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CNT_W  = $clog2(MAX_ROUTES + 1);

	state_t state_q, state_d;

	// Fill count and scan position.
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;

	// Latched word.
	logic        op_q;
	logic [31:0] key_q;
	logic [5:0]  len_q;
	logic        has_gw_q;
	logic [31:0] gw_q;
	logic [2:0]  iface_q;
	logic [7:0]  ttl_q;

	// Best entry found so far.
	logic              best_vld_q;
	logic [5:0]        best_len_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [2:0]        best_iface_q;
	logic [31:0]       best_addr_q;

	// Result registers.
	logic        done_q;
	logic [2:0]  status_q;
	logic [2:0]  iface_out_q;
	logic [31:0] addr_out_q;
	logic [7:0]  ttl_out_q;

	// Sequencer outputs.
	logic              accept;
	logic              low_ttl;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              cnt_inc;
	logic [2:0]        res_status;
	logic [2:0]        res_iface;
	logic [31:0]       res_addr;
	logic [7:0]        res_ttl;

	entry_t   wr_data;
	entry_t   rd_data;
	cmp_res_t cmp;

	assign accept  = start && (state_q == S_IDLE);
	assign low_ttl = (ttl_in <= 8'd1);

	lpr_table #(
		.DEPTH  (MAX_ROUTES),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	lpr_cmp u_cmp (
		.ent      (rd_data),
		.key      (key_q),
		.key_len  (len_q),
		.best_vld (best_vld_q),
		.best_len (best_len_q),
		.res      (cmp)
	);

	assign wr_data = '{prefix: key_q, length: len_q, iface: iface_q,
		has_gw: has_gw_q, gw: gw_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if ((op == OP_ROUTE && low_ttl) || count_q == '0) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_q + CNT_W'(1) == count_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:  state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs and result selection.
	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = best_idx_q;
		cnt_inc    = 1'b0;
		res_status = ST_NO_ROUTE;
		res_iface  = '0;
		res_addr   = '0;
		res_ttl    = '0;
		unique case (state_q) inside
			S_IDLE, S_DRAIN: begin
			end
			S_SCAN: rd_en = 1'b1;
			S_FINISH: begin
				if (op_q == OP_ADD) begin
					if (best_vld_q) begin
						wr_en      = 1'b1;
						res_status = ST_STORED;
					end else if (count_q < CNT_W'(MAX_ROUTES)) begin
						wr_en      = 1'b1;
						wr_addr    = count_q[ADDR_W-1:0];
						cnt_inc    = 1'b1;
						res_status = ST_STORED;
					end else begin
						res_status = ST_TABLE_FULL;
					end
				end else if (ttl_q <= 8'd1) begin
					res_status = ST_DROPPED_TTL;
				end else if (best_vld_q && int'(best_iface_q) < NUM_INTERFACES) begin
					res_status = ST_FORWARDED;
					res_iface  = best_iface_q;
					res_addr   = best_addr_q;
					res_ttl    = ttl_q - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == S_FINISH);
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept) begin
				scan_q     <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				// Keep the first same route for an add, the longest hit for a lookup.
				if (rd_vld_s1) begin
					if (op_q == OP_ADD) begin
						if (cmp.same && !best_vld_q) begin
							best_vld_q <= 1'b1;
						end
					end else if (cmp.hit && cmp.longer) begin
						best_vld_q <= 1'b1;
					end
				end
			end
		end
	end

	// Payload registers of the word and of the best entry.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[ADDR_W-1:0];
		if (accept) begin
			op_q     <= op;
			len_q    <= clamp_len(route_len);
			key_q    <= (op == OP_ADD) ? (route_net & prefix_mask(route_len))
				: dst_addr;
			has_gw_q <= has_next_hop;
			gw_q     <= next_hop_addr;
			iface_q  <= route_interface;
			ttl_q    <= ttl_in;
		end
		if (!accept && rd_vld_s1) begin
			if (op_q == OP_ADD) begin
				if (cmp.same && !best_vld_q) begin
					best_idx_q <= rd_idx_s1;
				end
			end else if (cmp.hit && cmp.longer) begin
				best_len_q   <= rd_data.length;
				best_iface_q <= rd_data.iface;
				best_addr_q  <= rd_data.has_gw ? rd_data.gw : key_q;
			end
		end
		if (state_q == S_FINISH) begin
			status_q    <= res_status;
			iface_out_q <= res_iface;
			addr_out_q  <= res_addr;
			ttl_out_q   <= res_ttl;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign out_interface = iface_out_q;
	assign deliver_addr  = addr_out_q;
	assign ttl_out       = ttl_out_q;

endmodule

// ----- hdl/lpr_table.sv -----
// Route table memory with one write port and one registered read port.
module lpr_table #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  lpr_pkg::entry_t     wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output lpr_pkg::entry_t     rd_data
);
	import lpr_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/lpr_cmp.sv -----
// Shared compare unit that judges one stored route against the current key.
module lpr_cmp (
	input  lpr_pkg::entry_t   ent,
	input  logic [31:0]       key,
	input  logic [5:0]        key_len,
	input  logic              best_vld,
	input  logic [5:0]        best_len,
	output lpr_pkg::cmp_res_t res
);
	import lpr_pkg::*;

	// Same route for an add, prefix hit and length ranking for a lookup.
	always_comb begin
		res.same   = (ent.length == key_len) && (ent.prefix == key);
		res.hit    = ((key & prefix_mask(ent.length)) == ent.prefix);
		res.longer = !best_vld || (ent.length > best_len);
	end

endmodule

// ----- hdl/lpr_checker.sv -----
// Port-level checker for the route lookup block and its bind to the top level.
module lpr_checker #(
	parameter int NUM_INTERFACES = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [2:0]  out_interface,
	input logic [31:0] deliver_addr,
	input logic [7:0]  ttl_out
);
	import lpr_pkg::*;

	// A result is shown only once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// An accepted word always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// Status carries one of the five codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_STORED || status == ST_FORWARDED ||
			status == ST_DROPPED_TTL || status == ST_NO_ROUTE ||
			status == ST_TABLE_FULL))
		else $error("status code out of range");

	// Only a forwarded header carries payload fields.
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_FORWARDED) |->
			(out_interface == '0 && deliver_addr == '0 && ttl_out == '0))
		else $error("payload fields set on a result that is not forwarded");

	// A forwarded header has a live TTL and a legal interface.
	a_forward_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FORWARDED) |->
			(ttl_out != '0 && int'(out_interface) < NUM_INTERFACES))
		else $error("forwarded result with bad TTL or interface");

endmodule

bind ipv4_longest_prefix_router lpr_checker #(
	.NUM_INTERFACES (NUM_INTERFACES)
) u_lpr_checker (.*);
